>>> sv/dpc_pkg.sv
// Shared types and constants for the debounced press up/down counter.
// No dependencies; imported by every module of the block.
package dpc_pkg;

	// Default width of the elapsed-tick counter
	localparam int TICK_WIDTH_DEF = 16;

	// Fixed field widths
	localparam int CFG_TICK_W  = 16;
	localparam int COUNT_W     = 4;
	localparam int PHASE_W     = 3;
	localparam int CFG_INDEX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT      = 2'd2;

	// Configuration reset values
	localparam logic [CFG_TICK_W-1:0] DEBOUNCE_RESET   = 16'd40;
	localparam logic [CFG_TICK_W-1:0] LONG_PRESS_RESET = 16'd3000;
	localparam logic [COUNT_W-1:0]    LIMIT_RESET      = 4'hF;

	// Button debounce phases
	typedef enum logic [PHASE_W-1:0] {
		PH_RELEASED = 3'd0,
		PH_BOUNCING = 3'd1,
		PH_EDGE     = 3'd2,
		PH_PRESSED  = 3'd3,
		PH_LONG     = 3'd4,
		PH_RISING   = 3'd5
	} phase_t;

	// Debounce and counter control state
	typedef struct packed {
		phase_t               phase;
		logic [COUNT_W-1:0]   counter;
		logic                 counting_down;
	} ctrl_t;

endpackage

>>> sv/debounced_press_updown_counter.sv
// A sample beat passes through the sample register, then the result register,
// which holds while result_stall is high. One sample per cycle is taken unless the
// result register is full and stalled, which stalls the sample side.
// Asynchronous active-low reset: phase released, tick count and counter zero,
// counting up, registers at their defaults, both registers empty.
// Depends on dpc_pkg and dpc_step.
module debounced_press_updown_counter import dpc_pkg::*; #(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample channel
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic                   button_level,
	input  logic                   ms_tick,
	// result channel
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [COUNT_W-1:0]     count_value,
	output logic [PHASE_W-1:0]     button_phase,
	output logic                   press_pulse,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_TICK_W-1:0]  cfg_data
);

	logic                  valid_s1;
	logic                  button_s1;
	logic                  tick_s1;
	ctrl_t                 ctrl_q;
	ctrl_t                 ctrl_next;
	logic [TICK_WIDTH-1:0] elapsed_q;
	logic [TICK_WIDTH-1:0] elapsed_next;
	logic                  pulse_next;
	logic [CFG_TICK_W-1:0] debounce_q;
	logic [CFG_TICK_W-1:0] long_press_q;
	logic [COUNT_W-1:0]    limit_q;
	logic                  result_valid_q;
	logic [COUNT_W-1:0]    count_q;
	logic [PHASE_W-1:0]    phase_q;
	logic                  pulse_q;
	logic                  advance;
	logic                  take;

	// Move the sample stage forward whenever the result register is free
	assign advance      = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign take         = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
			limit_q      <= LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_LIMIT:      limit_q      <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance || !valid_s1)
			valid_s1 <= take;
	end

	// Sample register: payload
	always_ff @(posedge clk) begin
		if (take) begin
			button_s1 <= button_level;
			tick_s1   <= ms_tick;
		end
	end

	dpc_step #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_step (
		.button_level     (button_s1),
		.ms_tick          (tick_s1),
		.cur              (ctrl_q),
		.elapsed          (elapsed_q),
		.debounce_ticks   (debounce_q),
		.long_press_ticks (long_press_q),
		.count_limit      (limit_q),
		.nxt              (ctrl_next),
		.elapsed_next     (elapsed_next),
		.press_pulse      (pulse_next)
	);

	// Commit state when the sample beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q         <= '{phase: PH_RELEASED, counter: '0, counting_down: 1'b0};
			elapsed_q      <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				ctrl_q    <= ctrl_next;
				elapsed_q <= elapsed_next;
			end
		end
	end

	// Result payload; hold while stalled
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			count_q <= ctrl_next.counter;
			phase_q <= ctrl_next.phase;
			pulse_q <= pulse_next;
		end
	end

	assign result_valid = result_valid_q;
	assign count_value  = count_q;
	assign button_phase = phase_q;
	assign press_pulse  = pulse_q;

endmodule

>>> sv/dpc_step.sv
// Next-state logic for one button sample: debounce phase, tick count, counter.
// Depends on dpc_pkg.
module dpc_step import dpc_pkg::*; #(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic                  button_level,
	input  logic                  ms_tick,
	input  ctrl_t                 cur,
	input  logic [TICK_WIDTH-1:0] elapsed,
	input  logic [CFG_TICK_W-1:0] debounce_ticks,
	input  logic [CFG_TICK_W-1:0] long_press_ticks,
	input  logic [COUNT_W-1:0]    count_limit,
	output ctrl_t                 nxt,
	output logic [TICK_WIDTH-1:0] elapsed_next,
	output logic                  press_pulse
);

	localparam int CMP_W = (TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W;

	logic [TICK_WIDTH-1:0] elapsed_cnt;
	logic [CMP_W-1:0]      elapsed_ext;
	logic [CMP_W-1:0]      debounce_ext;
	logic [CMP_W-1:0]      long_ext;
	logic                  step_down;
	logic [COUNT_W-1:0]    stepped;

	// Count the tick first, saturating at all ones
	always_comb begin
		elapsed_cnt = elapsed;
		if (ms_tick && (elapsed != {TICK_WIDTH{1'b1}}))
			elapsed_cnt = elapsed + TICK_WIDTH'(1);
	end

	assign elapsed_ext  = CMP_W'(elapsed_cnt);
	assign debounce_ext = CMP_W'(debounce_ticks);
	assign long_ext     = CMP_W'(long_press_ticks);

	// Ping-pong step: turn at the limit or at zero, never go below zero
	always_comb begin
		step_down = cur.counting_down;
		if (cur.counter >= count_limit)
			step_down = 1'b1;
		else if (cur.counter == '0)
			step_down = 1'b0;
		stepped = cur.counter;
		if (!step_down)
			stepped = cur.counter + COUNT_W'(1);
		else if (cur.counter != '0)
			stepped = cur.counter - COUNT_W'(1);
	end

	// Phase transitions
	always_comb begin
		nxt          = cur;
		elapsed_next = elapsed_cnt;
		press_pulse  = 1'b0;
		unique case (cur.phase)
			PH_BOUNCING: begin
				if (button_level) begin
					nxt.phase = PH_RELEASED;
				end else if (elapsed_ext >= debounce_ext) begin
					nxt.phase         = PH_EDGE;
					elapsed_next      = '0;
					press_pulse       = 1'b1;
					nxt.counter       = stepped;
					nxt.counting_down = step_down;
				end
			end
			PH_EDGE: begin
				nxt.phase = PH_PRESSED;
			end
			PH_PRESSED: begin
				if (!button_level && (elapsed_ext > long_ext))
					nxt.phase = PH_LONG;
				else if (button_level)
					nxt.phase = PH_RISING;
			end
			PH_LONG: begin
				if (button_level)
					nxt.phase = PH_PRESSED;
			end
			PH_RISING: begin
				nxt.phase = button_level ? PH_RELEASED : PH_PRESSED;
			end
			default: begin
				if (!button_level) begin
					nxt.phase    = PH_BOUNCING;
					elapsed_next = '0;
				end else begin
					nxt.phase = PH_RELEASED;
				end
			end
		endcase
	end

endmodule

>>> sv/dpc_checker.sv
// Port-level assertions for the debounced press up/down counter, and the
// bind that attaches them to the top level. Depends on dpc_pkg.
module dpc_checker import dpc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   sample_stall,
	input logic                   result_valid,
	input logic                   result_stall,
	input logic [COUNT_W-1:0]     count_value,
	input logic [PHASE_W-1:0]     button_phase,
	input logic                   press_pulse
);

	// A press pulse only ever comes with the press edge phase
	a_pulse_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && press_pulse) |-> (button_phase == PH_EDGE))
		else $error("press pulse outside press edge phase");

	// The sample side stalls only behind a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("sample stalled without a stalled result");

	// The press edge phase lasts exactly one result beat
	a_edge_once: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && button_phase == PH_EDGE)
		##1 result_valid |-> (button_phase == PH_PRESSED))
		else $error("press edge not followed by pressed");

	// A stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
		(result_valid && $stable(count_value) && $stable(button_phase)
		&& $stable(press_pulse)))
		else $error("stalled result beat changed");

endmodule

bind debounced_press_updown_counter dpc_checker u_dpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.count_value  (count_value),
	.button_phase (button_phase),
	.press_pulse  (press_pulse)
);

>>> sim/dpc_counter_checker.sv
// Watches the sample, result and register channels of the debounced press counter,
// mirrors its button phase and ping-pong counter, and compares every result beat.
// Depends on dpc_pkg.
module dpc_counter_checker import dpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   sample_stall,
	input  logic                   button_level,
	input  logic                   ms_tick,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic [COUNT_W-1:0]     count_value,
	input  logic [PHASE_W-1:0]     button_phase,
	input  logic                   press_pulse,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_TICK_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     beats_checked,
	output int                     presses,
	output int                     long_entries
);

	localparam int TICK_W = TICK_WIDTH_DEF;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		phase_t             phase;
		logic               pulse;
	} press_beat_t;

	// Mirrored register file
	logic [CFG_TICK_W-1:0] debounce;
	logic [CFG_TICK_W-1:0] long_press;
	logic [COUNT_W-1:0]    limit;

	// Mirrored button and counter state
	phase_t                btn_phase;
	logic [TICK_W-1:0]     elapsed;
	logic [COUNT_W-1:0]    count;
	logic                  counting_down;

	press_beat_t           due_beats[$];

	task automatic flag_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		fail_count++;
	endtask

	// Advance the mirrored state by one pin sample and return the beat it must produce
	function automatic press_beat_t advance_button(input logic level, input logic tick);
		press_beat_t beat;
		logic        pulse;
		pulse = 1'b0;
		// count the tick first, holding at all ones
		if (tick && elapsed != '1)
			elapsed = elapsed + 1'b1;
		case (btn_phase)
			PH_BOUNCING: begin
				if (level) begin
					btn_phase = PH_RELEASED;
				end else if (elapsed >= debounce) begin
					btn_phase = PH_EDGE;
					elapsed = '0;
					pulse = 1'b1;
					presses++;
					// ping-pong step: turn at the limit or at zero, never go below zero
					if (count >= limit)
						counting_down = 1'b1;
					else if (count == '0)
						counting_down = 1'b0;
					if (!counting_down)
						count = count + 1'b1;
					else if (count != '0)
						count = count - 1'b1;
				end
			end
			PH_EDGE: btn_phase = PH_PRESSED;
			PH_PRESSED: begin
				if (!level && elapsed > long_press) begin
					btn_phase = PH_LONG;
					long_entries++;
				end else if (level) begin
					btn_phase = PH_RISING;
				end
			end
			PH_LONG: begin
				if (level)
					btn_phase = PH_PRESSED;
			end
			PH_RISING: btn_phase = level ? PH_RELEASED : PH_PRESSED;
			default: begin
				if (!level) begin
					btn_phase = PH_BOUNCING;
					elapsed = '0;
				end else begin
					btn_phase = PH_RELEASED;
				end
			end
		endcase
		beat.count = count;
		beat.phase = btn_phase;
		beat.pulse = pulse;
		return beat;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		press_beat_t want;
		if (!arst_n) begin
			debounce = DEBOUNCE_RESET;
			long_press = LONG_PRESS_RESET;
			limit = LIMIT_RESET;
			btn_phase = PH_RELEASED;
			elapsed = '0;
			count = '0;
			counting_down = 1'b0;
			due_beats.delete();
			pending = 0;
			fail_count = 0;
			beats_checked = 0;
			presses = 0;
			long_entries = 0;
		end else begin
			// compare the result beat with the oldest prediction
			if (result_valid && !result_stall) begin
				beats_checked++;
				if (due_beats.size() == 0) begin
					flag_error($sformatf(
						"result beat with nothing predicted: count %0d phase %0d pulse %0b",
						count_value, button_phase, press_pulse));
				end else begin
					want = due_beats.pop_front();
					if (count_value !== want.count)
						flag_error($sformatf("count_value %0d, predicted %0d",
							count_value, want.count));
					if (button_phase !== want.phase)
						flag_error($sformatf("button_phase %0d, predicted %0d",
							button_phase, want.phase));
					if (press_pulse !== want.pulse)
						flag_error($sformatf("press_pulse %0b, predicted %0b",
							press_pulse, want.pulse));
				end
			end
			// predict from the sample beat taken at this edge
			if (sample_valid && !sample_stall)
				due_beats.push_back(advance_button(button_level, ms_tick));
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE:   debounce = cfg_data;
					REG_LONG_PRESS: long_press = cfg_data;
					REG_LIMIT:      limit = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			pending = due_beats.size();
		end
	end

endmodule

>>> sim/debounced_press_updown_counter_tb.sv
// Testbench top for the debounced press up/down counter: clock, reset, pin samples,
// register writes, random stalls and the verdict.
// Depends on dpc_pkg, debounced_press_updown_counter and dpc_counter_checker.
module debounced_press_updown_counter_tb;
	import dpc_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int RUN_LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD = 30;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   sample_valid;
	logic                   sample_stall;
	logic                   button_level;
	logic                   ms_tick;
	logic                   result_valid;
	logic                   result_stall;
	logic [COUNT_W-1:0]     count_value;
	logic [PHASE_W-1:0]     button_phase;
	logic                   press_pulse;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_TICK_W-1:0]  cfg_data;

	int fail_count;
	int pending;
	int beats_checked;
	int presses;
	int long_entries;
	int samples_sent;
	int settings_used;
	int phase_end;
	bit quiet;

	logic [CFG_TICK_W-1:0] cur_debounce;
	logic [CFG_TICK_W-1:0] cur_long;

	debounced_press_updown_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.button_level (button_level),
		.ms_tick      (ms_tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.count_value  (count_value),
		.button_phase (button_phase),
		.press_pulse  (press_pulse),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	dpc_counter_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.button_level  (button_level),
		.ms_tick       (ms_tick),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.count_value   (count_value),
		.button_phase  (button_phase),
		.press_pulse   (press_pulse),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.beats_checked (beats_checked),
		.presses       (presses),
		.long_entries  (long_entries)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#(CLK_PERIOD * RUN_LIMIT_CYCLES);
		$display("debounced_press_updown_counter verification failed");
		$finish;
	end

	// Stall the result channel now and then, except in the quiet stretch
	always @(negedge clk) begin
		result_stall <= !quiet && ($urandom_range(0, 99) < 7);
	end

	// Offer one sample beat; entered and left just after a falling edge
	task automatic send_sample(input logic level, input logic tick);
		while (!quiet && $urandom_range(0, 99) < 7) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		button_level <= level;
		ms_tick <= tick;
		do @(posedge clk); while (sample_stall);
		samples_sent++;
		@(negedge clk);
	endtask

	// Hold off samples until every predicted beat has come back
	task automatic drain_results();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_TICK_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Load all three registers; the limit write carries random upper bits
	task automatic apply_setting(input logic [CFG_TICK_W-1:0] deb,
			input logic [CFG_TICK_W-1:0] lp, input logic [COUNT_W-1:0] lim);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_LONG_PRESS, lp);
		write_reg(REG_LIMIT, {12'($urandom_range(0, 4095)), lim});
		cur_debounce = deb;
		cur_long = lp;
		settings_used++;
	endtask

	// One press: bounce in, hold low with ticks, bounce out, settle high
	task automatic press_burst();
		int bounces;
		int span;
		bounces = $urandom_range(0, 3);
		span = 2 * (int'(cur_debounce) + int'(cur_long)) + 6;
		if (span > 120)
			span = 120;
		repeat (bounces) begin
			send_sample(1'b0, 1'($urandom_range(0, 1)));
			send_sample(1'b1, 1'($urandom_range(0, 1)));
		end
		repeat ($urandom_range(0, span))
			send_sample(1'b0, $urandom_range(0, 99) < 60);
		bounces = $urandom_range(0, 2);
		repeat (bounces) begin
			send_sample(1'b1, 1'($urandom_range(0, 1)));
			send_sample(1'b0, 1'($urandom_range(0, 1)));
		end
		repeat ($urandom_range(1, 3))
			send_sample(1'b1, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		button_level = 1'b1;
		ms_tick = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		quiet = 1'b0;
		samples_sent = 0;
		settings_used = 1;
		cur_debounce = DEBOUNCE_RESET;
		cur_long = LONG_PRESS_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default registers: bounce in and out without reaching the debounce time
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b0);

		// Zero debounce, zero long press and zero limit; spare index is ignored
		drain_results();
		write_reg(REG_SPARE, 16'hFFFF);
		apply_setting(16'd0, 16'd0, 4'd0);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b0);
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b0);
		send_sample(1'b1, 1'b1);
		send_sample(1'b1, 1'b0);

		// Limit of one: counter turns 0, 1, 0; a long hold stays short of long press
		drain_results();
		apply_setting(16'd1, 16'hFFFF, 4'd1);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		repeat (LONG_HOLD) send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b0);
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b1);
		send_sample(1'b1, 1'b1);

		// Random presses under several register settings, one of them without idling
		for (int p = 0; p < 8; p++) begin
			drain_results();
			case (p)
				0: apply_setting(16'hFFFF, 16'hFFFF, 4'd15);
				1: apply_setting(16'd1, 16'd1, 4'd1);
				2: apply_setting(16'd0, 16'd0, 4'd15);
				default: apply_setting(16'($urandom_range(0, 6)), 16'($urandom_range(0, 25)),
					4'($urandom_range(0, 15)));
			endcase
			quiet = (p == 3);
			phase_end = samples_sent + ((p == 0) ? 100 : 200);
			while (samples_sent < phase_end) begin
				if ($urandom_range(0, 99) < 10)
					send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				else
					press_burst();
				if ($urandom_range(0, 39) == 0)
					drain_results();
			end
		end
		quiet = 1'b0;

		// Let the last beats come home, then give any stray beats time to show
		drain_results();
		repeat (8) @(posedge clk);
		$display("Run covered %0d sample beats under %0d register settings.", samples_sent,
			settings_used);
		$display("Checked %0d result beats, %0d debounced presses, %0d long-press entries.",
			beats_checked, presses, long_entries);
		if (fail_count == 0) begin
			$display("debounced_press_updown_counter verification clean");
		end else begin
			$display("debounced_press_updown_counter verification failed");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/dpc_pkg.sv
sv/dpc_step.sv
sv/debounced_press_updown_counter.sv
sv/dpc_checker.sv
sim/dpc_counter_checker.sv
sim/debounced_press_updown_counter_tb.sv
